>>> design/ctb_pkg.sv
// Shared types and constants for the cascaded timer bank.
package ctb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int NIBBLE_BITS = 4;
    localparam int FRAC_BITS   = 16;

    localparam int REQ_W    = 3;
    localparam int SEL_W    = 4;
    localparam int CYC_W    = 8;
    localparam int VAL_W    = 64;
    localparam int CNT_W    = 32;
    localparam int MASK_W   = 16;
    localparam int PERIOD_W = 40;
    localparam int ACC_W    = 48;
    localparam int IDX_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // nibble bits
    localparam int CTL_ENABLE  = 0;
    localparam int CTL_RELOAD  = 1;
    localparam int CTL_CASCADE = 2;

    typedef enum logic [REQ_W-1:0] {
        OP_TICK     = 3'd0,
        OP_WR_CNT   = 3'd1,
        OP_WR_RLD   = 3'd2,
        OP_RD_CNT   = 3'd3,
        OP_RD_RLD   = 3'd4,
        OP_SET_CTL  = 3'd5,
        OP_CLR_CTL  = 3'd6,
        OP_RD_CTL   = 3'd7
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             sel_ok;
        logic [IDX_W-1:0] idx;
        logic [CYC_W-1:0] cycles;
        logic [VAL_W-1:0] value;
    } t_cmd;

endpackage

>>> design/ctb_front.sv
// Front end: accepts requests and decodes them into queue commands.
module ctb_front (
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_req_type,
    input  logic [3:0]             i_timer_sel,
    input  logic [7:0]             i_cycles,
    input  logic [63:0]            i_value,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output ctb_pkg::t_cmd          o_cmd
);
    import ctb_pkg::*;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.op     = t_op'(i_req_type);
        o_cmd.sel_ok = (32'(i_timer_sel) < NUM_TIMERS);
        o_cmd.idx    = i_timer_sel[IDX_W-1:0];
        o_cmd.cycles = i_cycles;
        o_cmd.value  = i_value;
    end

endmodule

>>> design/ctb_fifo.sv
// Short command queue between the front and back ends.
module ctb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ctb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ctb_pkg::t_cmd o_cmd
);
    import ctb_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

endmodule

>>> design/ctb_div.sv
// Restoring divider, one quotient bit per cycle: accumulator over tick period.
module ctb_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ctb_pkg::ACC_W-1:0]    i_dividend,
    input  logic [ctb_pkg::PERIOD_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [ctb_pkg::ACC_W-1:0]    o_quotient,
    output logic [ctb_pkg::PERIOD_W-1:0] o_remainder
);
    import ctb_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0]     r_quo;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_dvs;
    logic [PERIOD_W:0]    trial;
    logic                 ge;

    assign trial = {r_rem, r_quo[ACC_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? PERIOD_W'(trial - {1'b0, r_dvs}) : trial[PERIOD_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> design/ctb_back.sv
// Back end: timer state, command execution, bank steps and result register.
module ctb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  ctb_pkg::t_cmd                i_cmd,
    output logic                         o_cmd_pop,
    input  logic [ctb_pkg::PERIOD_W-1:0] i_period,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ctb_pkg::VAL_W-1:0]    o_rsp_data,
    output logic [ctb_pkg::MASK_W-1:0]   o_raised_mask
);
    import ctb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_STEP, S_OUT} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt [NUM_TIMERS];
    logic [CNT_W-1:0]    r_rld [NUM_TIMERS];
    logic [VAL_W-1:0]    r_ctl;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_steps;
    logic [MASK_W-1:0]   r_raised;
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_rsp_data;
    logic [MASK_W-1:0]   r_raised_mask;

    logic                out_free;
    logic                out_load;
    logic [VAL_W-1:0]    rd_val;
    logic [ACC_W-1:0]    acc_sum;
    logic [PERIOD_W-1:0] divisor;
    logic                div_start;
    logic                div_done;
    logic [ACC_W-1:0]    div_quo;
    logic [PERIOD_W-1:0] div_rem;
    logic [CNT_W-1:0]    n_cnt [NUM_TIMERS];
    logic [VAL_W-1:0]    n_ctl;
    logic [MASK_W-1:0]   step_raised;
    logic                any_en;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign out_load   = (o_cmd_pop && (i_cmd.op != OP_TICK)) ||
                        ((r_state == S_OUT) && out_free);
    assign acc_sum    = r_acc + (ACC_W'(i_cmd.cycles) << FRAC_BITS);
    assign divisor    = (i_period == '0) ? PERIOD_W'(1) : i_period;
    assign div_start  = o_cmd_pop && (i_cmd.op == OP_TICK);

    assign o_out_valid   = r_out_valid;
    assign o_rsp_data    = r_rsp_data;
    assign o_raised_mask = r_raised_mask;

    ctb_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (acc_sum),
        .i_divisor   (divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // read data for the command at the queue head
    always_comb begin
        rd_val = '0;
        unique case (i_cmd.op)
            OP_RD_CNT: if (i_cmd.sel_ok) rd_val = VAL_W'(r_cnt[i_cmd.idx]);
            OP_RD_RLD: if (i_cmd.sel_ok) rd_val = VAL_W'(r_rld[i_cmd.idx]);
            OP_RD_CTL: rd_val = r_ctl;
            default:   rd_val = '0;
        endcase
    end

    // One bank step; carry ripples up from timer 0.
    always_comb begin
        logic       carry;
        logic [3:0] nib;
        carry       = 1'b1;
        n_ctl       = r_ctl;
        step_raised = '0;
        any_en      = 1'b0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            nib      = r_ctl[t*NIBBLE_BITS +: NIBBLE_BITS];
            n_cnt[t] = r_cnt[t];
            any_en   = any_en | nib[CTL_ENABLE];
            if (!nib[CTL_ENABLE] || (nib[CTL_CASCADE] && !carry)) begin
                carry = 1'b0;
            end else if (r_cnt[t] != '0) begin
                n_cnt[t] = r_cnt[t] - 1'b1;
                carry    = 1'b0;
            end else begin
                if (nib[CTL_RELOAD]) begin
                    n_cnt[t] = r_rld[t];
                end else begin
                    n_cnt[t] = '0;
                    n_ctl[t*NIBBLE_BITS + CTL_ENABLE] = 1'b0;
                end
                carry          = 1'b1;
                step_raised[t] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ctl       <= '0;
            r_acc       <= '0;
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_cnt[t] <= '0;
                r_rld[t] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.op == OP_TICK) begin
                            r_acc    <= acc_sum;
                            r_raised <= '0;
                            r_state  <= S_DIV;
                        end else begin
                            r_raised_mask <= '0;
                            r_rsp_data    <= rd_val;
                            unique case (i_cmd.op)
                                OP_WR_CNT: if (i_cmd.sel_ok)
                                    r_cnt[i_cmd.idx] <= i_cmd.value[CNT_W-1:0];
                                OP_WR_RLD: if (i_cmd.sel_ok)
                                    r_rld[i_cmd.idx] <= i_cmd.value[CNT_W-1:0];
                                OP_SET_CTL: r_ctl <= r_ctl | i_cmd.value;
                                OP_CLR_CTL: r_ctl <= r_ctl & ~i_cmd.value;
                                default: ;
                            endcase
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_acc   <= ACC_W'(div_rem);
                        r_steps <= div_quo;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    // a bank with no enabled timer changes nothing
                    if (r_steps == '0 || r_ctl == '0 || !any_en) begin
                        r_state <= S_OUT;
                    end else begin
                        for (int t = 0; t < NUM_TIMERS; t++) begin
                            r_cnt[t] <= n_cnt[t];
                        end
                        r_ctl    <= n_ctl;
                        r_raised <= r_raised | step_raised;
                        r_steps  <= r_steps - 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_rsp_data    <= '0;
                        r_raised_mask <= r_raised;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/cascaded_timer_bank.sv
// Top level of the cascaded timer bank: request queue, executor, period register.
//
// Usage:
//   Request channel (i_in_valid/o_in_ready) carries one transaction per item:
//   tick, counter/reload write or read, control set/clear/read. Every request
//   yields exactly one result transaction on o_out_valid/i_out_ready with
//   o_rsp_data (reads only, else zero) and o_raised_mask (ticks only).
//   Config channel (i_cfg_valid/o_cfg_ready) writes the 40-bit tick period
//   (16 fraction bits, zero acts as one); it is always ready and must only be
//   used while the block is idle.
// Execution:
//   A two-entry queue sits between request decode and execution; an accepted
//   request is registered in the queue and the executor pops it from the head.
//   Non-tick requests load the result register as they are popped, one item
//   per cycle while the executor is idle and the output is not stalled. A tick
//   runs the bit-serial divider (accumulator over period), then the quotient
//   is taken as a step count, the bank steps run one by one, the step loop is
//   left and the result posted. With no enabled timer the step loop ends at once.
// Reset: synchronous, active low. Counters, reloads, control word and the
//   accumulator clear; the period returns to 2496610.
// Stall: a waiting result is held in the output register; the executor takes
//   no new command until it can post, and the queue then fills and drops
//   o_in_ready.
module cascaded_timer_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [39:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_timer_sel,
    input  logic [7:0]  i_cycles,
    input  logic [63:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_rsp_data,
    output logic [15:0] o_raised_mask
);
    import ctb_pkg::*;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2496610);

    logic [PERIOD_W-1:0] r_period;
    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    t_cmd                front_cmd;
    t_cmd                q_cmd;

    assign o_cfg_ready = 1'b1;

    // tick period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    ctb_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_timer_sel (i_timer_sel),
        .i_cycles    (i_cycles),
        .i_value     (i_value),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_cmd       (front_cmd)
    );

    ctb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    ctb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .i_period      (r_period),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rsp_data    (o_rsp_data),
        .o_raised_mask (o_raised_mask)
    );

endmodule
